[design/chte_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_pkg: shared types and constants
// Sizes, operation and status codes, transaction payloads, ctrl/dp interface.
// ----------------------------------------------------------------------------
package chte_pkg;

   localparam int NODES      = 64;
   localparam int BUCKETS    = 8;
   localparam int KEY_BITS   = 32;
   localparam int NODE_W     = 6;
   localparam int BKT_W      = 3;
   localparam int CNT_W      = 7;

   localparam logic [2:0] MODE_ALLOC    = 3'd0;
   localparam logic [2:0] MODE_INS_TAIL = 3'd1;
   localparam logic [2:0] MODE_INS_HEAD = 3'd2;
   localparam logic [2:0] MODE_LOOKUP   = 3'd3;
   localparam logic [2:0] MODE_UNLINK   = 3'd4;
   localparam logic [2:0] MODE_RELEASE  = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_EMPTY     = 2'd2;
   localparam logic [1:0] ST_BAD       = 2'd3;

   typedef struct packed {
      logic [2:0]          mode;
      logic [NODE_W-1:0]   node;
      logic [KEY_BITS-1:0] key;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] node_out;
      logic [1:0]        status;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request
      logic rd;       // issue node memory read at walk/link address
      logic commit;   // apply the operation's writes
      logic step;     // advance walk to next node
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [2:0] mode;
      logic       bad;       // request rejected up front
      logic       walk_done; // chain exhausted
      logic       hit;       // key compare matched
   } sts_type;

endpackage

[design/chte_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_datapath: node memories, bucket table and free FIFO
// Performs the reads and writes sequenced by the controller.
// ----------------------------------------------------------------------------
module chte_datapath
   import chte_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type result
);

   logic [KEY_BITS-1:0] key_mem  [NODES];
   logic [NODE_W-1:0]   next_mem [NODES];
   logic [NODE_W-1:0]   prev_mem [NODES];
   logic [NODE_W-1:0]   fifo_mem [NODES];
   logic [NODE_W-1:0]   head_ff  [BUCKETS];
   logic [NODE_W-1:0]   tail_ff  [BUCKETS];
   logic [CNT_W-1:0]    count_ff [BUCKETS];
   logic [NODES-1:0]    inb_ff;
   logic [NODES-1:0]    fvalid_ff;   // unwritten fifo entry i reads as i
   logic [NODE_W-1:0]   rptr_ff, wptr_ff;
   logic [CNT_W-1:0]    level_ff;

   req_type             r_ff;
   logic [NODE_W-1:0]   cur_ff, cur_in;
   logic [CNT_W-1:0]    idx_ff;
   logic [KEY_BITS-1:0] rkey_ff;
   logic [NODE_W-1:0]   rnext_ff, rprev_ff, fifo_q_ff;

   logic [BKT_W-1:0] bkt_req, bkt_node;
   logic [NODE_W-1:0] node_r;
   assign node_r   = r_ff.node;
   assign bkt_req  = r_ff.key[BKT_W-1:0];
   assign bkt_node = rkey_ff[BKT_W-1:0];

   // read address: walk pointer for lookup, else request node
   logic [NODE_W-1:0] raddr;
   assign raddr = (r_ff.mode == MODE_LOOKUP) ? cur_ff : node_r;

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rkey_ff   <= key_mem[raddr];
         rnext_ff  <= next_mem[raddr];
         rprev_ff  <= prev_mem[raddr];
         fifo_q_ff <= fifo_mem[rptr_ff];
      end
   end

   always_comb begin
      cur_in = cur_ff;
      if (cmd.load)      cur_in = head_ff[req.key[BKT_W-1:0]];
      else if (cmd.step) cur_in = rnext_ff;
   end

   logic bad_c;
   always_comb begin
      case (r_ff.mode)
         MODE_ALLOC:    bad_c = (level_ff == '0);
         MODE_INS_TAIL,
         MODE_INS_HEAD: bad_c = inb_ff[node_r];
         MODE_LOOKUP:   bad_c = 1'b0;
         MODE_UNLINK:   bad_c = !inb_ff[node_r];
         MODE_RELEASE:  bad_c = inb_ff[node_r] || (level_ff >= CNT_W'(NODES));
         default:       bad_c = 1'b1;
      endcase
   end

   assign sts.mode      = r_ff.mode;
   assign sts.bad       = bad_c;
   assign sts.walk_done = (idx_ff >= count_ff[bkt_req]);
   assign sts.hit       = (rkey_ff == r_ff.key);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         r_ff   <= req;
         idx_ff <= '0;
      end else if (cmd.step) begin
         idx_ff <= idx_ff + 1'b1;
      end
      cur_ff <= cur_in;
   end

   // payload memories (no reset)
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         case (r_ff.mode)
            MODE_INS_TAIL: begin
               key_mem[node_r] <= r_ff.key;
               if (count_ff[bkt_req] != '0) begin
                  next_mem[tail_ff[bkt_req]] <= node_r;
                  prev_mem[node_r]           <= tail_ff[bkt_req];
               end
            end
            MODE_INS_HEAD: begin
               key_mem[node_r] <= r_ff.key;
               if (count_ff[bkt_req] != '0) begin
                  prev_mem[head_ff[bkt_req]] <= node_r;
                  next_mem[node_r]           <= head_ff[bkt_req];
               end
            end
            MODE_UNLINK: begin
               if (head_ff[bkt_node] != node_r && tail_ff[bkt_node] != node_r) begin
                  next_mem[rprev_ff] <= rnext_ff;
                  prev_mem[rnext_ff] <= rprev_ff;
               end
            end
            MODE_RELEASE: fifo_mem[wptr_ff] <= node_r;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         case (r_ff.mode)
            MODE_INS_TAIL: begin
               if (count_ff[bkt_req] == '0) head_ff[bkt_req] <= node_r;
               tail_ff[bkt_req] <= node_r;
            end
            MODE_INS_HEAD: begin
               if (count_ff[bkt_req] == '0) tail_ff[bkt_req] <= node_r;
               head_ff[bkt_req] <= node_r;
            end
            MODE_UNLINK: begin
               if (head_ff[bkt_node] == node_r && tail_ff[bkt_node] != node_r)
                  head_ff[bkt_node] <= rnext_ff;
               else if (tail_ff[bkt_node] == node_r && head_ff[bkt_node] != node_r)
                  tail_ff[bkt_node] <= rprev_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inb_ff    <= '0;
         fvalid_ff <= '0;
         rptr_ff   <= '0;
         wptr_ff   <= '0;
         level_ff  <= CNT_W'(NODES);
         for (int i = 0; i < BUCKETS; i++) count_ff[i] <= '0;
      end else if (cmd.commit) begin
         case (r_ff.mode)
            MODE_ALLOC: begin
               rptr_ff  <= (rptr_ff == NODE_W'(NODES-1)) ? '0 : rptr_ff + 1'b1;
               level_ff <= level_ff - 1'b1;
            end
            MODE_INS_TAIL, MODE_INS_HEAD: begin
               inb_ff[node_r]    <= 1'b1;
               count_ff[bkt_req] <= count_ff[bkt_req] + 1'b1;
            end
            MODE_UNLINK: begin
               inb_ff[node_r] <= 1'b0;
               if (count_ff[bkt_node] != '0)
                  count_ff[bkt_node] <= count_ff[bkt_node] - 1'b1;
            end
            MODE_RELEASE: begin
               fvalid_ff[wptr_ff] <= 1'b1;
               wptr_ff  <= (wptr_ff == NODE_W'(NODES-1)) ? '0 : wptr_ff + 1'b1;
               level_ff <= level_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   // result formed from current state (valid when controller finishes)
   always_comb begin
      result = '{node_out: '0, status: ST_OK};
      case (r_ff.mode)
         MODE_ALLOC: begin
            if (level_ff == '0) result.status = ST_EMPTY;
            else result.node_out = fvalid_ff[rptr_ff] ? fifo_q_ff : rptr_ff;
         end
         MODE_LOOKUP: begin
            if (!sts.walk_done && sts.hit) result.node_out = cur_ff;
            else result.status = ST_NOT_FOUND;
         end
         MODE_INS_TAIL, MODE_INS_HEAD, MODE_UNLINK, MODE_RELEASE: begin
            if (bad_c) result.status = ST_BAD;
            else result.node_out = node_r;
         end
         default: result.status = ST_BAD;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      level_ff <= CNT_W'(NODES))
      else $error("free level overflow");
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit && r_ff.mode == MODE_ALLOC |-> level_ff != '0)
      else $error("alloc committed on empty pool");
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.commit))
      else $error("load and commit together");

endmodule

[design/chte_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_ctrl: operation sequencer
// Accepts a transaction, reads, walks or commits, then holds the response.
// ----------------------------------------------------------------------------
module chte_ctrl
   import chte_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   input  rsp_type result,
   output rsp_type rsp_data,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_WAIT  = 3'd2;
   localparam logic [2:0] S_DEC   = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   // new transaction can enter once the previous response slot frees
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: state_in = S_DEC;
         S_DEC: begin
            if (sts.mode == MODE_LOOKUP && !sts.walk_done && !sts.hit) begin
               cmd.step = 1'b1;
               state_in = S_READ;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            rsp_in       = result;
            rsp_valid_in = 1'b1;
            cmd.commit   = !sts.bad;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> state_ff == S_RESP)
      else $error("commit outside response state");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESP |-> !rsp_valid_ff || rsp_ready)
      else $error("response overwritten");
   assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> sts.mode == MODE_LOOKUP)
      else $error("walk step outside lookup");

endmodule

[design/chained_hash_table_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_engine_top: hashed node pool with free FIFO
// Top level joining the sequencer and the table datapath.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel carries one transaction (mode, node, key); rsp_ returns
//    exactly one (node_out, status) per request, in order.
//  - Operations other than lookup go from accept to rsp_valid through
//    a read issue, a read wait, a decision and a commit/response state.
//  - Lookup walks the bucket chain one node at a time (registered
//    node memory read then key compare); a hit reads up to the
//    matching node and a miss reads chain length + 1 nodes.
//  - One transaction in flight; req_ready returns high once the engine is
//    idle and the response register is empty or being drained in the
//    same cycle.
//  - A stalled rsp_ready holds the response and blocks new commits.
//  - Reset: all nodes free (FIFO order 0 upward), every bucket empty; the
//    FIFO initial contents are modeled by per-entry valid bits, so no
//    clearing pass is needed.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_top
   import chte_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;
   rsp_type result;

   chte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .result    (result),
      .rsp_data  (rsp_data),
      .cmd       (cmd)
   );

   chte_datapath u_dp (
      .clock  (clock),
      .reset  (reset),
      .req    (req_data),
      .cmd    (cmd),
      .sts    (sts),
      .result (result)
   );

endmodule
